@@ design/rectangle_sum_table_defines.svh @@
// Assertion macros used by the rectangle sum table engine.
`ifndef RECTANGLE_SUM_TABLE_DEFINES_SVH
`define RECTANGLE_SUM_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge of clk outside reset.
`define RST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that an expression is never true outside reset.
`define RST_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`else

`define RST_ASSERT(lbl, prop, msg)
`define RST_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

@@ design/rst_pkg.sv @@
// Shared types, constants and helpers of the rectangle sum table.
package rst_pkg;

	localparam int SUM_W     = 48;
	localparam int SAMPLE_W  = 32;
	localparam int DIM_W     = 9;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b1;

	// Input function codes
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

	// Grid size and restart pulse, top level to engine
	typedef struct packed {
		logic             restart;
		logic [DIM_W-1:0] height;
		logic [DIM_W-1:0] width;
	} cfg_t;

	// Finished query result, engine to output register
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             err;
	} res_t;

	// Map zero to one and cap at the largest supported size.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
		logic [DIM_W-1:0] res;
		if (v == '0) begin
			res = DIM_W'(1);
		end else if (int'(v) > maxv) begin
			res = DIM_W'(maxv);
		end else begin
			res = v;
		end
		return res;
	endfunction

endpackage

@@ design/rectangle_sum_table.sv @@
// Top level of the rectangle sum table: configuration, engine, table, output register.
//
// Loads stream grid samples in raster order; each load reads the entry one row above, then
// writes the new prefix sum, and a load after the grid is complete is dropped. A query
// reads its four corners one per cycle through the single read port of the table, between
// its accept and hand-off states; a query that fails the range or loaded check goes
// straight to hand-off. One item is in work at a time, but a finished result waits in the
// output register so the next item can be accepted. The table is not cleared after reset;
// configuration writes are taken in every cycle and restart loading.
module rectangle_sum_table
	import rst_pkg::*;
#(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 func,
	input  logic [SAMPLE_W-1:0]  sample,
	input  logic [DIM_W-1:0]     top_row,
	input  logic [DIM_W-1:0]     left_col,
	input  logic [DIM_W-1:0]     bottom_row,
	input  logic [DIM_W-1:0]     right_col,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [SUM_W-1:0]     rect_sum,
	output logic                 error
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DIM_W-1:0] height_q, width_q;
	cfg_t             cfg;
	logic             res_valid, res_ready;
	res_t             res;
	logic             out_valid_q;
	logic [SUM_W-1:0] rect_sum_q;
	logic             error_q;
	logic             wr_en;
	logic [AW-1:0]    wr_addr, rd_addr;
	logic [SUM_W-1:0] wr_data, rd_data;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= clamp_dim(DIM_RESET, MAX_ROWS);
			width_q  <= clamp_dim(DIM_RESET, MAX_COLS);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GRID_HEIGHT: height_q <= clamp_dim(cfg_data, MAX_ROWS);
				REG_GRID_WIDTH:  width_q  <= clamp_dim(cfg_data, MAX_COLS);
			endcase
		end
	end

	assign cfg.restart = cfg_valid;
	assign cfg.height  = height_q;
	assign cfg.width   = width_q;

	rst_engine #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.AW       (AW)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.sample     (sample),
		.top_row    (top_row),
		.left_col   (left_col),
		.bottom_row (bottom_row),
		.right_col  (right_col),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

	rst_table_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Output register: take a new beat when empty or being drained
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rect_sum_q <= res.sum;
			error_q    <= res.err;
		end
	end

	assign out_valid = out_valid_q;
	assign rect_sum  = rect_sum_q;
	assign error     = error_q;

endmodule

@@ design/rst_table_mem.sv @@
// Prefix table storage: one write port, one registered read port.
module rst_table_mem
	import rst_pkg::*;
#(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [SUM_W-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [SUM_W-1:0] rd_data
);

	logic [SUM_W-1:0] mem_q [DEPTH];
	logic [SUM_W-1:0] rd_data_q;

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read one entry, data in the next cycle
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/rst_engine.sv @@
// Load and query sequencer: read-modify-write for loads, four reads for queries.
`include "rectangle_sum_table_defines.svh"

module rst_engine
	import rst_pkg::*;
#(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256,
	parameter int AW       = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                func,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [DIM_W-1:0]    top_row,
	input  logic [DIM_W-1:0]    left_col,
	input  logic [DIM_W-1:0]    bottom_row,
	input  logic [DIM_W-1:0]    right_col,
	output logic                res_valid,
	input  logic                res_ready,
	output res_t                res,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output logic [SUM_W-1:0]    wr_data,
	output logic [AW-1:0]       rd_addr,
	input  logic [SUM_W-1:0]    rd_data
);

	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int MW    = (RW > CW) ? RW : CW;
	localparam int CMP_W = ((MW > DIM_W) ? MW : DIM_W) + 1;
	localparam logic [2:0] QIDX_LAST = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_LOAD  = 4'b0010,
		ST_QUERY = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	state_t            state_q;
	logic [2:0]        qidx_q;
	logic [DIM_W-1:0]  r1_q, c1_q, r2_q, c2_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [SUM_W-1:0]  acc_q;
	logic              err_q;
	logic              sign_s1, zero_s1;
	logic [SUM_W-1:0]  row_sum_q;
	logic [RW-1:0]     load_row_q;
	logic [CW-1:0]     load_col_q;
	logic              loaded_q;

	logic              in_acc;
	logic              query_bad;
	logic [DIM_W-1:0]  cr, cc;
	logic              csub, czero;
	logic [AW-1:0]     q_addr, load_rd_addr;
	logic [SUM_W-1:0]  rs_new, above, term;
	logic              col_last, row_last;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;

	// Flag corners past the configured size and queries before the grid is full
	assign query_bad = !loaded_q || (top_row > cfg.height) || (bottom_row > cfg.height) ||
		(left_col > cfg.width) || (right_col > cfg.width);

	// Pick the corner and its sign for the current read
	always_comb begin
		cr   = r2_q;
		cc   = c2_q;
		csub = 1'b0;
		unique case (qidx_q[1:0])
			2'd0: begin
				cr = r2_q; cc = c2_q; csub = 1'b0;
			end
			2'd1: begin
				cr = r1_q; cc = c2_q; csub = 1'b1;
			end
			2'd2: begin
				cr = r2_q; cc = c1_q; csub = 1'b1;
			end
			2'd3: begin
				cr = r1_q; cc = c1_q; csub = 1'b0;
			end
		endcase
	end

	// Row zero and column zero of the prefix grid read as zero
	assign czero  = (cr == '0) || (cc == '0);
	assign q_addr = czero ? '0 : AW'((int'(cr) - 1) * MAX_COLS + int'(cc) - 1);

	// Entry one row above the next load position
	assign load_rd_addr = (load_row_q == '0) ? '0 :
		AW'((int'(load_row_q) - 1) * MAX_COLS + int'(load_col_q));

	assign rd_addr = (state_q == ST_QUERY) ? q_addr : load_rd_addr;

	// Prefix sum of the current sample
	assign rs_new  = row_sum_q + {{(SUM_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
	assign above   = (load_row_q == '0) ? '0 : rd_data;
	assign wr_en   = (state_q == ST_LOAD);
	assign wr_addr = AW'(int'(load_row_q) * MAX_COLS + int'(load_col_q));
	assign wr_data = rs_new + above;

	assign col_last = (CMP_W'(load_col_q) + CMP_W'(1)) == CMP_W'(cfg.width);
	assign row_last = (CMP_W'(load_row_q) + CMP_W'(1)) == CMP_W'(cfg.height);

	// Signed contribution of the corner read in the previous cycle
	assign term = zero_s1 ? '0 : (sign_s1 ? (SUM_W'(0) - rd_data) : rd_data);

	assign res_valid = (state_q == ST_OUT);
	assign res.sum   = acc_q;
	assign res.err   = err_q;

	// Sequencer and load position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			qidx_q     <= '0;
			row_sum_q  <= '0;
			load_row_q <= '0;
			load_col_q <= '0;
			loaded_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (func == FUNC_QUERY) begin
							qidx_q  <= '0;
							state_q <= query_bad ? ST_OUT : ST_QUERY;
						end else if (!loaded_q) begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_IDLE;
					if (col_last) begin
						load_col_q <= '0;
						row_sum_q  <= '0;
						if (row_last) begin
							load_row_q <= '0;
							loaded_q   <= 1'b1;
						end else begin
							load_row_q <= load_row_q + RW'(1);
						end
					end else begin
						load_col_q <= load_col_q + CW'(1);
						row_sum_q  <= rs_new;
					end
				end
				ST_QUERY: begin
					qidx_q <= qidx_q + 3'd1;
					if (qidx_q == QIDX_LAST) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// Restart loading on any configuration write
			if (cfg.restart) begin
				row_sum_q  <= '0;
				load_row_q <= '0;
				load_col_q <= '0;
				loaded_q   <= 1'b0;
			end
		end
	end

	// Capture item payload and accumulate the corner terms
	always_ff @(posedge clk) begin
		sign_s1 <= csub;
		zero_s1 <= czero;
		if (in_acc) begin
			sample_q <= sample;
			r1_q     <= top_row;
			c1_q     <= left_col;
			r2_q     <= bottom_row;
			c2_q     <= right_col;
			acc_q    <= '0;
			err_q    <= query_bad;
		end else if (state_q == ST_QUERY && qidx_q != '0) begin
			acc_q <= acc_q + term;
		end
	end

	`RST_ASSERT(a_drop_full_load, (in_acc && func == FUNC_LOAD && loaded_q) |=> !wr_en, "load after full grid wrote the table")
	`RST_ASSERT(a_err_zero_sum, (res_valid && res.err) |-> (res.sum == '0), "error result with nonzero sum")
	`RST_ASSERT(a_restart_clears, cfg.restart |=> (!loaded_q && load_col_q == '0 && load_row_q == '0), "restart did not clear load position")
	`RST_ASSERT_NEVER(a_col_range, CMP_W'(load_col_q) >= CMP_W'(cfg.width), "load column past grid width")
	`RST_ASSERT_NEVER(a_qidx_range, (state_q == ST_QUERY) && (qidx_q > QIDX_LAST), "query read index overran")

endmodule

@@ dv/tb_rectangle_sum_table.sv @@
// Self-checking testbench for the rectangle sum table: grid loads and rectangle queries.
`timescale 1ns / 100ps

module tb_rectangle_sum_table
	import rst_pkg::*;
();

	localparam int MAX_ROWS      = 256;
	localparam int MAX_COLS      = 256;
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 120;

	typedef struct {
		logic                func;
		logic [SAMPLE_W-1:0] sample;
		logic [DIM_W-1:0]    top;
		logic [DIM_W-1:0]    left;
		logic [DIM_W-1:0]    bottom;
		logic [DIM_W-1:0]    right;
	} table_op_t;

	typedef struct {
		logic [SUM_W-1:0] sum;
		logic             err;
	} rect_answer_t;

	logic                 clk;
	logic                 arst_n     = 1'b0;
	logic                 cfg_valid  = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [DIM_W-1:0]     cfg_data   = '0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic                 func       = FUNC_LOAD;
	logic [SAMPLE_W-1:0]  sample     = '0;
	logic [DIM_W-1:0]     top_row    = '0;
	logic [DIM_W-1:0]     left_col   = '0;
	logic [DIM_W-1:0]     bottom_row = '0;
	logic [DIM_W-1:0]     right_col  = '0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic [SUM_W-1:0]     rect_sum;
	logic                 error;

	// Stimulus and expectation stores
	table_op_t    grid_ops[$];
	rect_answer_t rect_sums_due[$];
	int unsigned  ops_in_flight = 0;
	int unsigned  random_items  = 0;
	int unsigned  in_gap        = 0;
	int unsigned  out_stall     = 0;
	int unsigned  quiet         = 0;
	int           fail_count    = 0;
	bit           in_took       = 1'b0;
	bit           gaps_on       = 1'b1;

	// Predicted block state
	bit [SUM_W-1:0] psum_tbl [MAX_ROWS*MAX_COLS];
	bit [SUM_W-1:0] row_acc   = '0;
	int unsigned    ld_row    = 0;
	int unsigned    ld_col    = 0;
	bit             grid_full = 1'b0;
	int unsigned    grid_h    = MAX_ROWS;
	int unsigned    grid_w    = MAX_COLS;

	rectangle_sum_table DUT (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned fit_dim(logic [DIM_W-1:0] v, int unsigned limit);
		if (v == '0)
			return 1;
		return (v > limit) ? limit : v;
	endfunction

	// Prefix sum at corner (r, c); the top row and left column of corners read as zero
	function automatic bit [SUM_W-1:0] psum_at(int unsigned r, int unsigned c);
		if (r == 0 || c == 0)
			return '0;
		return psum_tbl[(r - 1) * MAX_COLS + (c - 1)];
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (!gaps_on || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return SAMPLE_W'($urandom_range(0, 20)) - SAMPLE_W'(10);
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t ns: %s", $time, what);
		fail_count++;
	endtask

	// Size write: clamp the value and restart loading
	task automatic take_reg_write(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
		if (idx == REG_GRID_HEIGHT) begin
			grid_h = fit_dim(val, MAX_ROWS);
		end else begin
			grid_w = fit_dim(val, MAX_COLS);
		end
		row_acc   = '0;
		ld_row    = 0;
		ld_col    = 0;
		grid_full = 1'b0;
	endtask

	// Advance the table for a load, or queue the expected sum for a query
	task automatic apply_table_op(table_op_t op);
		bit [SUM_W-1:0] above;
		rect_answer_t   ans;
		if (op.func == FUNC_LOAD) begin
			if (grid_full)
				return;
			row_acc = row_acc + {{(SUM_W-SAMPLE_W){op.sample[SAMPLE_W-1]}}, op.sample};
			above = psum_at(ld_row, ld_col + 1);
			psum_tbl[ld_row * MAX_COLS + ld_col] = row_acc + above;
			ld_col++;
			if (ld_col >= grid_w) begin
				ld_col  = 0;
				row_acc = '0;
				ld_row++;
				if (ld_row >= grid_h) begin
					ld_row    = 0;
					grid_full = 1'b1;
				end
			end
		end else begin
			if (!grid_full || op.top > grid_h || op.bottom > grid_h ||
					op.left > grid_w || op.right > grid_w) begin
				ans.sum = '0;
				ans.err = 1'b1;
			end else begin
				ans.sum = psum_at(op.bottom, op.right) - psum_at(op.top, op.right)
					- psum_at(op.bottom, op.left) + psum_at(op.top, op.left);
				ans.err = 1'b0;
			end
			rect_sums_due.push_back(ans);
		end
	endtask

	task automatic push_op(table_op_t op);
		grid_ops.push_back(op);
		ops_in_flight++;
	endtask

	// Unused fields carry random junk
	task automatic push_load(logic [SAMPLE_W-1:0] s);
		table_op_t op;
		op.func   = FUNC_LOAD;
		op.sample = s;
		op.top    = $urandom;
		op.left   = $urandom;
		op.bottom = $urandom;
		op.right  = $urandom;
		push_op(op);
	endtask

	task automatic push_query(int unsigned t, int unsigned l, int unsigned b, int unsigned r);
		table_op_t op;
		op.func   = FUNC_QUERY;
		op.sample = $urandom;
		op.top    = DIM_W'(t);
		op.left   = DIM_W'(l);
		op.bottom = DIM_W'(b);
		op.right  = DIM_W'(r);
		push_op(op);
	endtask

	// Mostly corners inside the grid, now and then anywhere in the field range
	task automatic push_rand_query();
		if ($urandom_range(0, 7) == 0) begin
			push_query($urandom_range(0, 511), $urandom_range(0, 511),
				$urandom_range(0, 511), $urandom_range(0, 511));
		end else begin
			push_query($urandom_range(0, grid_h), $urandom_range(0, grid_w),
				$urandom_range(0, grid_h), $urandom_range(0, grid_w));
		end
		random_items++;
	endtask

	// Hold until every beat is taken and every sum is back, then let the engine finish
	task automatic wait_idle();
		while (ops_in_flight != 0 || rect_sums_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One random grid: new size, raster loads, then queries
	task automatic run_round();
		int unsigned h, w, cells, roll;
		roll = $urandom_range(0, 9);
		h = (roll == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
		w = (roll == 1) ? $urandom_range(9, 24) : $urandom_range(1, 6);
		wait_idle();
		// write one or both sizes; a zero height now and then acts as one
		roll = $urandom_range(0, 5);
		if (roll != 0)
			write_reg(REG_GRID_HEIGHT, (roll == 1) ? '0 : DIM_W'(h));
		if (roll != 5)
			write_reg(REG_GRID_WIDTH, DIM_W'(w));
		if (grid_h * grid_w > 600) begin
			write_reg(REG_GRID_HEIGHT, DIM_W'(h));
			write_reg(REG_GRID_WIDTH, DIM_W'(w));
		end
		gaps_on = ($urandom_range(0, 3) != 0);
		cells = grid_h * grid_w;
		// abandon loading early now and then; the next size write restarts it
		if ($urandom_range(0, 7) == 0)
			cells = $urandom_range(0, cells - 1);
		for (int i = 0; i < cells; i++) begin
			push_load(pick_sample());
			random_items++;
			if ($urandom_range(0, 24) == 0)
				push_rand_query();
		end
		// surplus loads past a complete grid are dropped
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 2)) push_load(pick_sample());
		if ($urandom_range(0, 3) == 0)
			wait_idle();
		repeat ($urandom_range(3, 10)) push_rand_query();
	endtask

	// Present the next beat once the previous one is taken and any gap has run out
	always @(negedge clk) begin : feed
		table_op_t op;
		if (!in_valid || in_took) begin
			in_took = 1'b0;
			if (in_gap != 0 || grid_ops.size() == 0 || !arst_n) begin
				if (in_gap != 0)
					in_gap--;
				in_valid <= 1'b0;
			end else begin
				op = grid_ops.pop_front();
				in_valid   <= 1'b1;
				func       <= op.func;
				sample     <= op.sample;
				top_row    <= op.top;
				left_col   <= op.left;
				bottom_row <= op.bottom;
				right_col  <= op.right;
				in_gap = pick_gap();
			end
		end
	end

	// Stall the result side at random
	always @(negedge clk) begin : sink
		if (out_stall != 0) begin
			out_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			out_stall = pick_gap();
		end
	end

	// Check result beats, track accepted beats and register writes, watch for a hang
	always @(posedge clk) begin : watch
		table_op_t    op;
		rect_answer_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (rect_sums_due.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected: sum %0d error %0b",
						$signed(rect_sum), error));
				end else begin
					want = rect_sums_due.pop_front();
					if (rect_sum !== want.sum)
						report_mismatch($sformatf("rect_sum %0d, expected %0d",
							$signed(rect_sum), $signed(want.sum)));
					if (error !== want.err)
						report_mismatch($sformatf("error %0b, expected %0b", error, want.err));
				end
			end
			if (cfg_valid && cfg_ready)
				take_reg_write(cfg_index, cfg_data);
			if (in_valid && in_ready) begin
				op.func   = func;
				op.sample = sample;
				op.top    = top_row;
				op.left   = left_col;
				op.bottom = bottom_row;
				op.right  = right_col;
				apply_table_op(op);
				ops_in_flight--;
				in_took = 1'b1;
			end
			if ((out_valid && out_ready) || (cfg_valid && cfg_ready) || (in_valid && in_ready)) begin
				quiet = 0;
			end else if (++quiet >= STALL_LIMIT) begin
				$display("FAIL rectangle_sum_table");
				$finish;
			end
		end
	end

	initial begin : stimulus
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// queries before any grid is complete, then a partial load
		push_query(0, 0, MAX_ROWS, MAX_COLS);
		push_query(0, 0, 0, 0);
		repeat (3) push_load(pick_sample());
		wait_idle();

		// 2x2 grid of extreme samples
		write_reg(REG_GRID_HEIGHT, 9'd2);
		write_reg(REG_GRID_WIDTH, 9'd2);
		push_load(32'h7fff_ffff);
		push_load(32'h8000_0000);
		push_load(32'hffff_ffff);
		push_load(32'h0000_0000);
		push_load(32'h1234_5678);
		push_query(0, 0, 2, 2);
		push_query(2, 2, 0, 0);
		push_query(0, 2, 2, 0);
		push_query(1, 1, 2, 2);
		push_query(1, 0, 1, 2);
		push_query(0, 0, 3, 2);
		push_query(0, 0, 2, 256);
		push_query(511, 511, 511, 511);
		wait_idle();

		// zero sizes act as one
		write_reg(REG_GRID_HEIGHT, '0);
		write_reg(REG_GRID_WIDTH, '0);
		push_load(32'h8000_0000);
		push_query(0, 0, 1, 1);
		push_query(1, 1, 0, 0);
		wait_idle();

		// oversize height clamps to the full table height; one column of minimum samples
		write_reg(REG_GRID_HEIGHT, 9'h1ff);
		write_reg(REG_GRID_WIDTH, 9'd1);
		gaps_on = 1'b0;
		repeat (MAX_ROWS) push_load(32'h8000_0000);
		push_query(0, 0, 256, 1);
		push_query(256, 0, 0, 1);
		push_query(255, 0, 256, 1);
		push_query(128, 0, 129, 1);
		push_query(0, 0, 257, 1);
		wait_idle();
		gaps_on = 1'b1;

		while (random_items < RANDOM_ITEMS)
			run_round();
		wait_idle();

		if (fail_count == 0)
			$display("PASS rectangle_sum_table");
		else
			$display("FAIL rectangle_sum_table");
		$finish;
	end

endmodule
